@@ rtl/pal_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list package
// Shared constants, codes, state type and control/status bundles.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 11;
  localparam int POS_W    = 11;
  localparam int DATA_W   = 32;
  localparam int ACT_W    = 3;

  localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_POS   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INS_END   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REM_FRONT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REM_POS   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_REM_END   = 3'd5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT_UP,
    S_WRITE_NEW,
    S_REMOVE_RD,
    S_SHIFT_DN,
    S_FINISH_RM,
    S_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic check;
    logic shift_up;
    logic write_new;
    logic remove_rd;
    logic shift_dn;
    logic dec_count;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic fail;
    logic up_done;
    logic dn_done;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/positional_array_list.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list
// A bounded ordered list of 32-bit entries with insert and remove at the
// front, at a position or at the end.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low, and the block then
// stays busy until its one result beat has been shown. The result is on the
// status, removed_value and entry_count ports, marked by done for exactly one
// cycle, and the receiver cannot stall it. An insert moves the stored entries at
// and above its position, a remove those above it. A new command can be taken in
// the cycle after the beat. The entries move one a cycle through the single write
// port of the entry memory. A rejected command or an unused action code goes from
// the check straight to its result beat.
module positional_array_list
  import pal_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic [ACT_W-1:0]  action,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [DATA_W-1:0] entry_value,
  output      logic              done,
  output      logic [1:0]        status,
  output      logic [DATA_W-1:0] removed_value,
  output      logic [CNT_W-1:0]  entry_count
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  pal_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  pal_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .action        (action),
    .position      (position),
    .entry_value   (entry_value),
    .stat          (stat),
    .status        (status),
    .removed_value (removed_value),
    .entry_count   (entry_count)
  );

endmodule

`default_nettype wire

@@ rtl/pal_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/pal_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list controller
// Sequences the check, shift and finish phases of one command.
// ----------------------------------------------------------------------------
module pal_ctrl
  import pal_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output      ctl_cmd_t cmd,
  output      logic     busy,
  output      logic     done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.fail) begin
          state_next = S_DONE;
        end else if (stat.is_insert) begin
          state_next = S_SHIFT_UP;
        end else begin
          state_next = S_REMOVE_RD;
        end
      end
      S_SHIFT_UP: begin
        if (stat.up_done) begin
          state_next = S_WRITE_NEW;
        end
      end
      S_WRITE_NEW: state_next = S_DONE;
      S_REMOVE_RD: state_next = S_SHIFT_DN;
      S_SHIFT_DN: begin
        if (stat.dn_done) begin
          state_next = S_FINISH_RM;
        end
      end
      S_FINISH_RM: state_next = S_DONE;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = (state != S_IDLE);
    done      = 1'b0;
    case (state)
      S_IDLE:      cmd.latch     = start;
      S_CHECK:     cmd.check     = 1'b1;
      S_SHIFT_UP:  cmd.shift_up  = 1'b1;
      S_WRITE_NEW: cmd.write_new = 1'b1;
      S_REMOVE_RD: cmd.remove_rd = 1'b1;
      S_SHIFT_DN:  cmd.shift_dn  = 1'b1;
      S_FINISH_RM: cmd.dec_count = 1'b1;
      S_DONE:      done          = 1'b1;
      default:     cmd           = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/pal_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list datapath
// Command registers, fill count, entry memory and the shift pipeline.
// ----------------------------------------------------------------------------
module pal_dp
  import pal_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctl_cmd_t          cmd,
  input  wire logic [ACT_W-1:0]  action,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [DATA_W-1:0] entry_value,
  output      dp_stat_t          stat,
  output      logic [1:0]        status,
  output      logic [DATA_W-1:0] removed_value,
  output      logic [CNT_W-1:0]  entry_count
);

  logic [ACT_W-1:0]  act_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  target;
  logic [CNT_W-1:0]  idx;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;
  logic              first;
  status_t           stat_q;
  logic [DATA_W-1:0] removed_q;

  logic              is_ins;
  logic              is_rem;
  logic [CNT_W-1:0]  target_c;
  status_t           status_c;
  logic              up_issue;
  logic              dn_issue;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [CNT_W-1:0]  idx_dec;
  logic [CNT_W-1:0]  idx_inc;

  assign is_ins = (act_q == ACT_INS_FRONT) || (act_q == ACT_INS_POS) ||
                  (act_q == ACT_INS_END);
  assign is_rem = (act_q == ACT_REM_FRONT) || (act_q == ACT_REM_POS) ||
                  (act_q == ACT_REM_END);

  always_comb begin
    case (act_q)
      ACT_INS_FRONT: target_c = '0;
      ACT_INS_END:   target_c = count;
      ACT_REM_FRONT: target_c = '0;
      ACT_REM_END:   target_c = count - CNT_W'(1);
      default:       target_c = pos_q;
    endcase
  end

  always_comb begin
    status_c = ST_OK;
    if (is_ins) begin
      if (count >= CNT_W'(CAPACITY)) begin
        status_c = ST_FULL;
      end else if (target_c > count) begin
        status_c = ST_RANGE;
      end
    end else if (is_rem) begin
      if (count == '0) begin
        status_c = ST_EMPTY;
      end else if ((act_q == ACT_REM_POS) && (pos_q >= count)) begin
        status_c = ST_RANGE;
      end
    end
  end

  assign idx_dec  = idx - CNT_W'(1);
  assign idx_inc  = idx + CNT_W'(1);
  assign up_issue = (idx > target);
  assign dn_issue = (idx_inc < count);

  assign stat.is_insert = is_ins;
  assign stat.fail      = (status_c != ST_OK) || (!is_ins && !is_rem);
  assign stat.up_done   = !up_issue && !pend;
  assign stat.dn_done   = !dn_issue && !pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
      first <= 1'b0;
    end else begin
      if (cmd.check) begin
        pend <= 1'b0;
      end else if (cmd.shift_up) begin
        pend <= up_issue;
      end else if (cmd.shift_dn) begin
        pend <= dn_issue;
      end
      if (cmd.remove_rd) begin
        first <= 1'b1;
      end else if (cmd.shift_dn) begin
        first <= 1'b0;
      end
      if (cmd.write_new) begin
        count <= count + CNT_W'(1);
      end else if (cmd.dec_count) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_q     <= action;
      pos_q     <= position;
      val_q     <= entry_value;
      removed_q <= '0;
    end
    if (cmd.check) begin
      stat_q <= status_c;
      target <= target_c;
      idx    <= is_ins ? count : target_c;
    end
    if (cmd.shift_up) begin
      pend_addr <= idx[ADDR_W-1:0];
      if (up_issue) begin
        idx <= idx_dec;
      end
    end
    if (cmd.shift_dn) begin
      pend_addr <= idx[ADDR_W-1:0];
      if (dn_issue) begin
        idx <= idx_inc;
      end
      if (first) begin
        removed_q <= ram_rdata;
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata;
    ram_raddr = target[ADDR_W-1:0];
    if (cmd.write_new) begin
      ram_we    = 1'b1;
      ram_waddr = target[ADDR_W-1:0];
      ram_wdata = val_q;
    end else if (cmd.shift_up || cmd.shift_dn) begin
      ram_we = pend;
    end
    if (cmd.shift_up) begin
      ram_raddr = idx_dec[ADDR_W-1:0];
    end else if (cmd.shift_dn) begin
      ram_raddr = idx_inc[ADDR_W-1:0];
    end
  end

  pal_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign status        = stat_q;
  assign removed_value = removed_q;
  assign entry_count   = count;

endmodule

`default_nettype wire

@@ tb/tb_positional_array_list.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional array list testbench
// Sends insert and remove commands through the start/busy handshake and checks
// every done beat against an in-bench copy of the list. A short directed table
// covers the empty and out-of-range cases and the spare action codes.
// Random traffic then runs at small fill levels, grows the list to a deeper
// fill, and works on the deep list. The sender idles at random between commands.
// ----------------------------------------------------------------------------
module tb_positional_array_list;
  import pal_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned SMALL_ITEMS = 320;
  localparam int unsigned GROW_ITEMS  = 220;
  localparam int unsigned DEEP_ITEMS  = 24;

  typedef struct {
    status_t           st;
    logic [DATA_W-1:0] rem;
    logic [CNT_W-1:0]  cnt;
  } list_result_t;

  typedef struct {
    logic [ACT_W-1:0]  act;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    bit                typed;
    status_t           st;
    logic [DATA_W-1:0] rem;
    logic [CNT_W-1:0]  cnt;
  } cmd_row_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [ACT_W-1:0]  action;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] entry_value;
  logic              done;
  logic [1:0]        status;
  logic [DATA_W-1:0] removed_value;
  logic [CNT_W-1:0]  entry_count;

  logic [DATA_W-1:0] model_entries [CAPACITY];
  int unsigned       model_len;
  list_result_t      expected_results[$];
  int unsigned       mismatches;
  int unsigned       cycles;
  int unsigned       commands_sent;
  int unsigned       status_seen [4];
  int unsigned       peak_len;
  bit                no_gaps;

  cmd_row_t directed_rows [18] = '{
    '{ACT_REM_FRONT, 11'd0,    32'h0,         1'b1, ST_EMPTY, 32'h0, 11'd0},
    '{ACT_REM_POS,   11'd0,    32'h0,         1'b1, ST_EMPTY, 32'h0, 11'd0},
    '{ACT_REM_END,   11'd1024, 32'hFFFF_FFFF, 1'b1, ST_EMPTY, 32'h0, 11'd0},
    '{ACT_INS_POS,   11'd1,    32'h1234_5678, 1'b1, ST_RANGE, 32'h0, 11'd0},
    '{ACT_INS_POS,   11'd1024, 32'hFFFF_FFFF, 1'b1, ST_RANGE, 32'h0, 11'd0},
    '{ACT_INS_END,   11'd0,    32'hFFFF_FFFF, 1'b1, ST_OK,    32'h0, 11'd1},
    '{ACT_INS_FRONT, 11'd1024, 32'h0,         1'b1, ST_OK,    32'h0, 11'd2},
    '{ACT_INS_POS,   11'd2,    32'hA5A5_A5A5, 1'b0, ST_OK,    32'h0, 11'd0},
    '{ACT_INS_POS,   11'd1,    32'h5A5A_5A5A, 1'b0, ST_OK,    32'h0, 11'd0},
    '{ACT_REM_POS,   11'd4,    32'h0,         1'b1, ST_RANGE, 32'h0, 11'd4},
    '{ACT_REM_POS,   11'd1024, 32'h0,         1'b1, ST_RANGE, 32'h0, 11'd4},
    '{ACT_SPARE_6,   11'd0,    32'h0,         1'b1, ST_OK,    32'h0, 11'd4},
    '{ACT_SPARE_7,   11'd2047, 32'hFFFF_FFFF, 1'b1, ST_OK,    32'h0, 11'd4},
    '{ACT_REM_POS,   11'd1,    32'h0,         1'b0, ST_OK,    32'h0, 11'd0},
    '{ACT_REM_FRONT, 11'd0,    32'h0,         1'b0, ST_OK,    32'h0, 11'd0},
    '{ACT_REM_END,   11'd0,    32'h0,         1'b0, ST_OK,    32'h0, 11'd0},
    '{ACT_REM_END,   11'd0,    32'h0,         1'b0, ST_OK,    32'h0, 11'd0},
    '{ACT_REM_END,   11'd0,    32'h0,         1'b1, ST_EMPTY, 32'h0, 11'd0}
  };

  positional_array_list i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .position      (position),
    .entry_value   (entry_value),
    .done          (done),
    .status        (status),
    .removed_value (removed_value),
    .entry_count   (entry_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] exp_v,
                                 input logic [DATA_W-1:0] got_v);
    $display("MISMATCH at cycle %0d: %s expected 0x%0h got 0x%0h", cycles, what, exp_v,
             got_v);
    mismatches++;
  endtask

  task automatic predict_list_op(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                                 input logic [DATA_W-1:0] val, output list_result_t res);
    int unsigned at;
    res.st  = ST_OK;
    res.rem = '0;
    if (act == ACT_INS_FRONT || act == ACT_INS_POS || act == ACT_INS_END) begin
      at = (act == ACT_INS_FRONT) ? 0 : (act == ACT_INS_END) ? model_len : int'(pos);
      if (model_len >= CAPACITY) begin
        res.st = ST_FULL;
      end else if (at > model_len) begin
        res.st = ST_RANGE;
      end else begin
        for (int unsigned i = model_len; i > at; i--) model_entries[i] = model_entries[i-1];
        model_entries[at] = val;
        model_len++;
      end
    end else if (act == ACT_REM_FRONT || act == ACT_REM_POS || act == ACT_REM_END) begin
      at = (act == ACT_REM_FRONT) ? 0 : (act == ACT_REM_END) ? model_len - 1 : int'(pos);
      if (model_len == 0) begin
        res.st = ST_EMPTY;
      end else if (at >= model_len) begin
        res.st = ST_RANGE;
      end else begin
        res.rem = model_entries[at];
        for (int unsigned i = at; i + 1 < model_len; i++) model_entries[i] = model_entries[i+1];
        model_len--;
      end
    end
    res.cnt = model_len[CNT_W-1:0];
  endtask

  // Start stays high from one command to the next unless an idle gap lowers it.
  task automatic issue_cmd(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] val, input bit typed,
                           input list_result_t typed_res);
    list_result_t res;
    @(negedge clk);
    start       <= 1'b1;
    action      <= act;
    position    <= pos;
    entry_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_list_op(act, pos, val, res);
    expected_results.push_back(typed ? typed_res : res);
    commands_sent++;
    if (model_len > peak_len) peak_len = model_len;
  endtask

  task automatic idle_for(input int unsigned n);
    if (n != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(input bit for_insert);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      if (for_insert || model_len == 0) return POS_W'($urandom_range(0, model_len));
      return POS_W'($urandom_range(0, model_len - 1));
    end
    if (r < 80) return POS_W'(model_len);
    if (r < 90) return POS_W'($urandom_range(0, CAPACITY));
    return POS_W'(CAPACITY);
  endfunction

  task automatic random_cmd(input int unsigned insert_pct);
    logic [ACT_W-1:0] act;
    list_result_t     unused_res;
    bit               ins;
    ins = ($urandom_range(0, 99) < insert_pct);
    act = ACT_W'($urandom_range(0, 2) + (ins ? 0 : 3));
    unused_res = '{ST_OK, '0, '0};
    issue_cmd(act, pick_pos(ins), $urandom(), 1'b0, unused_res);
    idle_for(pick_gap());
  endtask

  always @(posedge clk) begin
    list_result_t exp_res;
    if (!rst && done) begin
      status_seen[status]++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending, entry_count", '0, 32'(entry_count));
      end else begin
        exp_res = expected_results.pop_front();
        if (status !== exp_res.st) report_mismatch("status", 32'(exp_res.st), 32'(status));
        if (removed_value !== exp_res.rem)
          report_mismatch("removed_value", exp_res.rem, removed_value);
        if (entry_count !== exp_res.cnt)
          report_mismatch("entry_count", 32'(exp_res.cnt), 32'(entry_count));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending", cycles,
               expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    list_result_t     row_res;
    logic [ACT_W-1:0] act;
    rst         = 1'b1;
    start       = 1'b0;
    action      = '0;
    position    = '0;
    entry_value = '0;
    cycles      = 0;
    mismatches  = 0;
    commands_sent = 0;
    peak_len    = 0;
    model_len   = 0;
    no_gaps     = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row_res = '{directed_rows[i].st, directed_rows[i].rem, directed_rows[i].cnt};
      issue_cmd(directed_rows[i].act, directed_rows[i].pos, directed_rows[i].val,
                directed_rows[i].typed, row_res);
      idle_for(pick_gap());
    end

    // Small fill levels keep each shift short while positions range from 0 to CAPACITY.
    for (int unsigned n = 0; n < SMALL_ITEMS; n++) begin
      if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      random_cmd(model_len > 40 ? 30 : 60);
    end

    // Mostly inserts, so the list grows and the shifts get long.
    for (int unsigned n = 0; n < GROW_ITEMS; n++) begin
      random_cmd(85);
    end

    row_res = '{ST_OK, '0, '0};
    issue_cmd(ACT_INS_FRONT, '0, $urandom(), 1'b0, row_res);
    issue_cmd(ACT_INS_POS, POS_W'(CAPACITY), $urandom(), 1'b0, row_res);
    issue_cmd(ACT_INS_END, '0, $urandom(), 1'b0, row_res);
    for (int unsigned n = 0; n < DEEP_ITEMS; n++) begin
      act = ACT_W'($urandom_range(0, 5));
      issue_cmd(act, pick_pos(act <= ACT_INS_END), $urandom(), 1'b0, row_res);
      idle_for(pick_gap());
    end

    @(negedge clk);
    start <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);

    $display("%0d commands, results ok/full/empty/range: %0d/%0d/%0d/%0d", commands_sent,
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_RANGE]);
    $display("peak fill %0d of %0d entries, %0d mismatches", peak_len, CAPACITY, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
